/* sv/rc4_pkg.sv */
// shared types and constants for the rc4 drop-n stream cipher core
`default_nettype none

package rc4_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int PERM_DEPTH = 256;

    // defaults for the top-level parameters
    localparam int DROP_BYTES_DEF = 256;
    localparam int KEY_MAX_DEF = 256;

    // input operation codes
    typedef enum logic {
        OP_KEY  = 1'b0,
        OP_DATA = 1'b1
    } op_t;

    // result request from the engine to the output register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              keyed;
    } res_t;

endpackage

`default_nettype wire

/* sv/rc4_add3.sv */
// shared 8-bit three-input adder used by the i, j and t index and sum steps
`default_nettype none

module rc4_add3 (
    input  wire logic [rc4_pkg::BYTE_W-1:0] a,
    input  wire logic [rc4_pkg::BYTE_W-1:0] b,
    input  wire logic [rc4_pkg::BYTE_W-1:0] c,
    output logic      [rc4_pkg::BYTE_W-1:0] sum
);
    import rc4_pkg::*;

    // modulo 256 sum
    assign sum = BYTE_W'(a + b + c);

endmodule

`default_nettype wire

/* sv/rc4_engine.sv */
// sequencer, permutation memory and key store of the rc4 core
`default_nettype none

module rc4_engine #(
    parameter int DROP_BYTES = rc4_pkg::DROP_BYTES_DEF,
    parameter int KEY_MAX    = rc4_pkg::KEY_MAX_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       in_op,
    input  wire logic [rc4_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                       in_last,
    input  wire logic                       out_free,
    output rc4_pkg::res_t                   res
);
    import rc4_pkg::*;

    localparam int KC_W = $clog2(KEY_MAX + 1);
    localparam int KA_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KW   = KC_W + 1;
    localparam int DW   = (DROP_BYTES > 0) ? $clog2(DROP_BYTES + 1) : 1;
    localparam bit NO_DROP = (DROP_BYTES == 0);
    localparam logic [BYTE_W-1:0] LAST_IDX = BYTE_W'(PERM_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_KSA_RD,
        S_KSA_J,
        S_KSA_WN,
        S_KSA_WJ,
        S_KS_RI,
        S_KS_RJ,
        S_KS_WI,
        S_KS_OUT,
        S_RAW_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [KC_W-1:0]   key_count_reg, key_count_next;
    logic [KA_W-1:0]   k_reg, k_next;
    logic [BYTE_W-1:0] n_reg, n_next;
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] sj_reg, sj_next;
    logic [BYTE_W-1:0] t_reg, t_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;
    logic              drop_mode_reg, drop_mode_next;
    logic [DW-1:0]     drop_cnt_reg, drop_cnt_next;
    logic              keyed_reg, keyed_next;

    // memories
    logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
    logic [BYTE_W-1:0] key_mem [KEY_MAX];
    logic [BYTE_W-1:0] prdata_reg;
    logic [BYTE_W-1:0] krdata_reg;
    logic              pwe;
    logic [BYTE_W-1:0] pwaddr;
    logic [BYTE_W-1:0] pwdata;
    logic [BYTE_W-1:0] praddr;
    logic              kwe;

    // shared adder
    logic [BYTE_W-1:0] add_a, add_b, add_c, add_sum;

    logic [KW-1:0]     k_inc;
    logic [BYTE_W-1:0] ks_byte;
    logic              accept;

    rc4_add3 u_add (
        .a   (add_a),
        .b   (add_b),
        .c   (add_c),
        .sum (add_sum)
    );

    // permutation memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (pwe) begin
            perm_mem[pwaddr] <= pwdata;
        end
        prdata_reg <= perm_mem[praddr];
    end

    // key store, written at the fill count and read at the key index
    always_ff @(posedge aclk) begin
        if (kwe) begin
            key_mem[key_count_reg[KA_W-1:0]] <= in_byte;
        end
        krdata_reg <= key_mem[k_reg];
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign k_inc    = KW'(k_reg) + KW'(1);

    // keystream byte with bypass of the swap still in flight
    always_comb begin
        if (t_reg == j_reg) begin
            ks_byte = si_reg;
        end else if (t_reg == i_reg) begin
            ks_byte = sj_reg;
        end else begin
            ks_byte = prdata_reg;
        end
    end

    // next state and datapath control
    always_comb begin
        state_next     = state_reg;
        key_count_next = key_count_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        t_next         = t_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        drop_mode_next = drop_mode_reg;
        drop_cnt_next  = drop_cnt_reg;
        keyed_next     = keyed_reg;
        pwe            = 1'b0;
        pwaddr         = n_reg;
        pwdata         = n_reg;
        praddr         = n_reg;
        kwe            = 1'b0;
        add_a          = '0;
        add_b          = '0;
        add_c          = '0;
        res            = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    data_next = in_byte;
                    last_next = in_last;
                    if (in_op == OP_KEY) begin
                        if (key_count_reg < KC_W'(KEY_MAX)) begin
                            kwe            = 1'b1;
                            key_count_next = key_count_reg + KC_W'(1);
                        end
                        if (in_last) begin
                            n_next     = '0;
                            state_next = S_FILL;
                        end
                    end else if (keyed_reg) begin
                        drop_mode_next = 1'b0;
                        state_next     = S_KS_RI;
                    end else begin
                        state_next = S_RAW_OUT;
                    end
                end
            end

            // identity fill, one entry a cycle
            S_FILL: begin
                pwe    = 1'b1;
                n_next = n_reg + BYTE_W'(1);
                if (n_reg == LAST_IDX) begin
                    j_next     = '0;
                    k_next     = '0;
                    state_next = S_KSA_RD;
                end
            end

            // key schedule swap step
            S_KSA_RD: begin
                praddr     = n_reg;
                state_next = S_KSA_J;
            end

            S_KSA_J: begin
                si_next    = prdata_reg;
                add_a      = j_reg;
                add_b      = prdata_reg;
                add_c      = krdata_reg;
                j_next     = add_sum;
                praddr     = add_sum;
                state_next = S_KSA_WN;
            end

            S_KSA_WN: begin
                pwe        = 1'b1;
                pwaddr     = n_reg;
                pwdata     = prdata_reg;
                state_next = S_KSA_WJ;
            end

            S_KSA_WJ: begin
                pwe    = 1'b1;
                pwaddr = j_reg;
                pwdata = si_reg;
                k_next = (k_inc >= KW'(key_count_reg)) ? '0 : KA_W'(k_inc);
                n_next = n_reg + BYTE_W'(1);
                if (n_reg == LAST_IDX) begin
                    i_next         = '0;
                    j_next         = '0;
                    drop_mode_next = 1'b1;
                    drop_cnt_next  = DW'(DROP_BYTES);
                    if (NO_DROP) begin
                        keyed_next     = 1'b1;
                        key_count_next = '0;
                        state_next     = S_IDLE;
                    end else begin
                        state_next = S_KS_RI;
                    end
                end else begin
                    state_next = S_KSA_RD;
                end
            end

            // keystream step: read s[i], read s[j], swap, read s[s[i]+s[j]]
            S_KS_RI: begin
                add_a      = i_reg;
                add_b      = BYTE_W'(1);
                i_next     = add_sum;
                praddr     = add_sum;
                state_next = S_KS_RJ;
            end

            S_KS_RJ: begin
                si_next    = prdata_reg;
                add_a      = j_reg;
                add_b      = prdata_reg;
                j_next     = add_sum;
                praddr     = add_sum;
                state_next = S_KS_WI;
            end

            S_KS_WI: begin
                sj_next    = prdata_reg;
                pwe        = 1'b1;
                pwaddr     = i_reg;
                pwdata     = prdata_reg;
                add_a      = si_reg;
                add_b      = prdata_reg;
                t_next     = add_sum;
                praddr     = add_sum;
                state_next = S_KS_OUT;
            end

            S_KS_OUT: begin
                pwe    = 1'b1;
                pwaddr = j_reg;
                pwdata = si_reg;
                praddr = t_reg;
                if (drop_mode_reg) begin
                    if (drop_cnt_reg == DW'(1)) begin
                        keyed_next     = 1'b1;
                        key_count_next = '0;
                        state_next     = S_IDLE;
                    end else begin
                        drop_cnt_next = drop_cnt_reg - DW'(1);
                        state_next    = S_KS_RI;
                    end
                end else if (out_free) begin
                    res.valid  = 1'b1;
                    res.data   = data_reg ^ ks_byte;
                    res.last   = last_reg;
                    res.keyed  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // data before any key
            S_RAW_OUT: begin
                if (out_free) begin
                    res.valid  = 1'b1;
                    res.data   = '0;
                    res.last   = last_reg;
                    res.keyed  = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            key_count_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            keyed_reg     <= 1'b0;
            drop_mode_reg <= 1'b0;
            drop_cnt_reg  <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            keyed_reg     <= keyed_next;
            drop_mode_reg <= drop_mode_next;
            drop_cnt_reg  <= drop_cnt_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
        end
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        t_reg    <= t_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

/* sv/rc4_drop256_stream_cipher_core.sv */
// top level of the rc4 drop-n stream cipher core with output register
//
// channel  dir  tdata            tuser      tlast
// s_       in   byte_in[7:0]     operation  last
// m_       out  byte_out[7:0]    keyed      last_res
//
// a key byte is stored while the key store has room; the final key byte also
// runs the identity fill, the key schedule and the drop of DROP_BYTES keystream
// bytes. a keyed data byte runs the keystream step, an unkeyed one S_RAW_OUT; the
// step makes three dependent reads and two writes; the permutation has one read
// and one write port. reset is synchronous and needs no memory clearing pass.
// a result waits in the output register; the engine holds its last step
// while that register is full and not taken.
`default_nettype none

module rc4_drop256_stream_cipher_core #(
    parameter int DROP_BYTES = rc4_pkg::DROP_BYTES_DEF,
    parameter int KEY_MAX    = rc4_pkg::KEY_MAX_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // byte_in[7:0]
    input  wire logic       s_tuser,   // operation
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // byte_out[7:0]
    output logic            m_tuser,   // keyed
    output logic            m_tlast
);
    import rc4_pkg::*;

    res_t              res;
    logic              out_free;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_keyed_reg;

    assign out_free = !out_valid_reg || m_tready;

    rc4_engine #(
        .DROP_BYTES (DROP_BYTES),
        .KEY_MAX    (KEY_MAX)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .out_free (out_free),
        .res      (res)
    );

    // output register, loaded by a result request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res.valid) begin
            out_data_reg  <= res.data;
            out_last_reg  <= res.last;
            out_keyed_reg <= res.keyed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_keyed_reg;

    // unkeyed results carry a zero byte
    a_unkeyed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("unkeyed result with nonzero byte");

    // the engine is never ready right after it accepts a data request
    a_data_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_DATA)) |=> !s_tready)
        else $error("engine ready right after a data request");

    // the engine never overwrites a result that is still waiting
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid) |-> (!m_tvalid || m_tready))
        else $error("result request while output register is full");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
